// ===== rtl/rtb_pkg.sv =====
// Shared types and constants for the retry timeout budget block.
`timescale 1ns / 1ps
`default_nettype none

package rtb_pkg;

    // Field widths
    localparam int SECS_W  = 16;
    localparam int COUNT_W = 6;
    localparam int INDEX_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [SECS_W-1:0]  TOTAL_RESET = '0;
    localparam logic [COUNT_W-1:0] COUNT_RESET = '0;
    localparam logic [SECS_W-1:0]  CAP_RESET   = SECS_W'(10);
    localparam logic [SECS_W-1:0]  SECS_MAX    = '1;

    // Operation codes
    typedef enum logic [1:0] {
        OP_FIRST = 2'd0,
        OP_DONE  = 2'd1,
        OP_RETRY = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOTAL = 2'd0,
        REG_COUNT = 2'd1,
        REG_CAP   = 2'd2,
        REG_SPARE = 2'd3
    } t_cfg_reg;

    // One input word
    typedef struct packed {
        t_opcode             opcode;
        logic [INDEX_W-1:0]  address_index;
        logic [SECS_W-1:0]   elapsed_seconds;
        logic [SECS_W-1:0]   spent_seconds;
        logic                expired;
        logic                was_capped;
    } t_item;

    // Configuration register set
    typedef struct packed {
        logic [SECS_W-1:0]  total_budget;
        logic [COUNT_W-1:0] address_count;
        logic [SECS_W-1:0]  try_cap;
    } t_cfg;

    // One result word
    typedef struct packed {
        logic              granted;
        logic [SECS_W-1:0] grant_seconds;
        logic              shortened;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/rtb_cfg_regs.sv =====
// Configuration register file of the retry timeout budget block.
`timescale 1ns / 1ps
`default_nettype none

module rtb_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [rtb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rtb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output rtb_pkg::t_cfg                      o_cfg
);
    import rtb_pkg::*;

    t_cfg r_cfg;

    // Write the addressed register; drop writes to the spare index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.total_budget  <= TOTAL_RESET;
            r_cfg.address_count <= COUNT_RESET;
            r_cfg.try_cap       <= CAP_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_TOTAL: r_cfg.total_budget  <= i_cfg_data[SECS_W-1:0];
                REG_COUNT: r_cfg.address_count <= i_cfg_data[COUNT_W-1:0];
                REG_CAP:   r_cfg.try_cap       <= i_cfg_data[SECS_W-1:0];
                default:   ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/rtb_in_stage.sv =====
// Input register stage of the retry timeout budget block.
`timescale 1ns / 1ps
`default_nettype none

module rtb_in_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_take,
    input  wire rtb_pkg::t_item i_item,
    output logic                o_valid,
    output rtb_pkg::t_item      o_item
);
    import rtb_pkg::*;

    logic  r_valid;
    t_item r_item;

    // Mark the stage full for one cycle per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_take;
        end
    end

    // Capture the payload on accept
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== rtl/rtb_exec.sv =====
// Budget evaluation, spent-time and deferred-address state, result register.
`timescale 1ns / 1ps
`default_nettype none

module rtb_exec #(
    parameter int DEFER_BITS = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire rtb_pkg::t_item i_item,
    input  wire rtb_pkg::t_cfg  i_cfg,
    output logic                o_done,
    output rtb_pkg::t_result    o_result
);
    import rtb_pkg::*;

    logic [SECS_W-1:0]     r_known;
    logic [DEFER_BITS-1:0] r_mask;
    logic                  r_done;
    t_result               r_result;

    logic [SECS_W-1:0]     n_known;
    logic [DEFER_BITS-1:0] n_mask;
    t_result               n_result;

    logic [SECS_W-1:0]     spent;
    logic [SECS_W-1:0]     left;
    logic                  unlimited;
    logic [COUNT_W-1:0]    idx_ext;
    logic [COUNT_W-1:0]    idx_next;
    logic [DEFER_BITS-1:0] idx_bit;
    logic                  is_deferred;
    logic [SECS_W:0]       sum;
    logic                  cap_first;

    // Remaining budget from the larger of caller time and known spend
    always_comb begin
        spent     = (i_item.elapsed_seconds < r_known) ? r_known : i_item.elapsed_seconds;
        unlimited = (i_cfg.total_budget == '0);
        left      = (unlimited || spent >= i_cfg.total_budget) ? '0
                                                              : i_cfg.total_budget - spent;
    end

    // Decode the address: bits above the mask width shift out to zero
    always_comb begin
        idx_ext     = COUNT_W'(i_item.address_index);
        idx_next    = idx_ext + COUNT_W'(1);
        idx_bit     = DEFER_BITS'(1) << i_item.address_index;
        is_deferred = |(r_mask & idx_bit);
        sum         = {1'b0, r_known} + {1'b0, i_item.spent_seconds};
        cap_first   = (idx_next < i_cfg.address_count) &&
                      (unlimited || left > i_cfg.try_cap);
    end

    // Evaluate one word and the state it leaves behind
    always_comb begin
        n_known  = r_known;
        n_mask   = r_mask;
        n_result = '0;
        case (i_item.opcode)
            OP_FIRST: begin
                if (idx_ext < i_cfg.address_count && !(!unlimited && left == '0)) begin
                    n_result.granted       = 1'b1;
                    n_result.shortened     = cap_first;
                    n_result.grant_seconds = cap_first ? i_cfg.try_cap : left;
                end
            end
            OP_DONE: begin
                if (i_item.expired) begin
                    n_known = sum[SECS_W] ? SECS_MAX : sum[SECS_W-1:0];
                    if (i_item.was_capped) begin
                        n_mask = r_mask | idx_bit;
                    end
                end
            end
            OP_RETRY: begin
                if (!unlimited && is_deferred && left > i_cfg.try_cap) begin
                    n_result.granted       = 1'b1;
                    n_result.grant_seconds = left;
                end
            end
            default: ;
        endcase
    end

    // Advance state and strobe the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known <= '0;
            r_mask  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_valid;
            if (i_valid) begin
                r_known <= n_known;
                r_mask  <= n_mask;
            end
        end
    end

    // Hold the result word
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== rtl/retry_timeout_budget_core.sv =====
// Top level of the retry timeout budget block.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------------
//  command  | i_start / o_busy      | i_opcode i_address_index i_elapsed_seconds
//           |                       | i_spent_seconds i_expired i_was_capped
//  result   | o_done (one cycle)    | o_granted o_grant_seconds o_shortened
//  config   | i_cfg_we              | i_cfg_index i_cfg_data
//
// One word per cycle; o_done and the result come through the input register, then the
// result register.
// o_busy stays low: the two-register path takes a word every cycle, and the
// spent-time and deferred state updates in the same cycle as the evaluation.
// Reset is synchronous: it clears the pipeline, the state and the registers.
// The result register holds its value until the next word is evaluated; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module retry_timeout_budget_core #(
    parameter int DEFER_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire logic [1:0]                    i_opcode,
    input  wire logic [rtb_pkg::INDEX_W-1:0]    i_address_index,
    input  wire logic [rtb_pkg::SECS_W-1:0]     i_elapsed_seconds,
    input  wire logic [rtb_pkg::SECS_W-1:0]     i_spent_seconds,
    input  wire logic                          i_expired,
    input  wire logic                          i_was_capped,
    output logic                               o_done,
    output logic                               o_granted,
    output logic [rtb_pkg::SECS_W-1:0]          o_grant_seconds,
    output logic                               o_shortened,
    input  wire logic                          i_cfg_we,
    input  wire logic [rtb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rtb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rtb_pkg::*;

    t_cfg    w_cfg;
    t_item   w_in_item;
    t_item   w_item;
    logic    w_item_valid;
    logic    w_take;
    t_result w_result;

    // Pack the command word
    always_comb begin
        w_in_item.opcode          = t_opcode'(i_opcode);
        w_in_item.address_index   = i_address_index;
        w_in_item.elapsed_seconds = i_elapsed_seconds;
        w_in_item.spent_seconds   = i_spent_seconds;
        w_in_item.expired         = i_expired;
        w_in_item.was_capped      = i_was_capped;
    end

    assign o_busy = 1'b0;
    assign w_take = i_start && !o_busy;

    rtb_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    rtb_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_item  (w_in_item),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    rtb_exec #(
        .DEFER_BITS (DEFER_BITS)
    ) u_exec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_item_valid),
        .i_item   (w_item),
        .i_cfg    (w_cfg),
        .o_done   (o_done),
        .o_result (w_result)
    );

    assign o_granted       = w_result.granted;
    assign o_grant_seconds = w_result.grant_seconds;
    assign o_shortened     = w_result.shortened;

`ifndef NO_ASSERTIONS
    // Every accepted word strobes a result through the input and result registers
    a_accept_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> ##1 o_done)
        else $error("accepted word produced no result");

    // A result strobe always traces back to an accepted word
    a_done_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_item_valid))
        else $error("result strobe without a word in the input stage");

    // A shortened attempt is granted exactly the per-try cap
    a_short_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_shortened) |-> (o_granted && o_grant_seconds == $past(w_cfg.try_cap)))
        else $error("shortened grant differs from the per-try cap");

    // A grant that is not shortened never exceeds a nonzero total budget
    a_grant_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_granted && !o_shortened && $past(w_cfg.total_budget) != '0)
            |-> (o_grant_seconds <= $past(w_cfg.total_budget)))
        else $error("grant exceeds the total budget");
`endif

endmodule

`default_nettype wire

// ===== tb/retry_budget_checker.sv =====
// Checker for the retry timeout budget core: predicts every grant word and compares it.
`timescale 1ns / 1ps

module retry_budget_checker #(
    parameter int DEFER_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic [1:0]                     i_opcode,
    input  logic [rtb_pkg::INDEX_W-1:0]    i_address_index,
    input  logic [rtb_pkg::SECS_W-1:0]     i_elapsed_seconds,
    input  logic [rtb_pkg::SECS_W-1:0]     i_spent_seconds,
    input  logic                           i_expired,
    input  logic                           i_was_capped,
    input  logic                           i_done,
    input  logic                           i_granted,
    input  logic [rtb_pkg::SECS_W-1:0]     i_grant_seconds,
    input  logic                           i_shortened,
    input  logic                           i_cfg_we,
    input  logic [rtb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rtb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_mismatches,
    output int                             o_grants_due
);
    import rtb_pkg::*;

    // Shadow copy of the registers and the budget state
    int                    budget_total;
    int                    addr_count;
    int                    cap_secs;
    int                    used_secs;
    logic [DEFER_BITS-1:0] deferred;

    t_result due_grants[$];
    t_item   word;
    t_result want;

    initial begin
        o_mismatches = 0;
        o_grants_due = 0;
    end

    task automatic flag_mismatch(input string what, input logic [15:0] got_v,
                                 input logic [15:0] want_v);
        $display("MISMATCH at %0t: %s got %0d, expected %0d", $time, what, got_v, want_v);
        o_mismatches++;
    endtask

    // Work out the grant for one word and advance the spent time and deferred set
    function automatic t_result budget_decide(input t_item w);
        t_result r;
        int      spent;
        int      left;
        int      sum;
        r = '0;
        spent = (w.elapsed_seconds < used_secs) ? used_secs : int'(w.elapsed_seconds);
        if (budget_total == 0 || spent >= budget_total) begin
            left = 0;
        end else begin
            left = budget_total - spent;
        end
        case (w.opcode)
            OP_FIRST: begin
                if (w.address_index < addr_count && !(budget_total != 0 && left == 0)) begin
                    r.shortened = (int'(w.address_index) + 1 < addr_count) &&
                                  (budget_total == 0 || left > cap_secs);
                    r.grant_seconds = r.shortened ? SECS_W'(cap_secs) : SECS_W'(left);
                    r.granted = 1'b1;
                end
            end
            OP_DONE: begin
                // Only a timed-out attempt costs budget
                if (w.expired) begin
                    sum = used_secs + int'(w.spent_seconds);
                    used_secs = (sum > int'(SECS_MAX)) ? int'(SECS_MAX) : sum;
                    if (w.was_capped && int'(w.address_index) < DEFER_BITS) begin
                        deferred[w.address_index] = 1'b1;
                    end
                end
            end
            OP_RETRY: begin
                if (budget_total != 0 && int'(w.address_index) < DEFER_BITS &&
                    deferred[w.address_index] && left > cap_secs) begin
                    r.grant_seconds = SECS_W'(left);
                end
                r.granted = (r.grant_seconds != '0);
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            budget_total = int'(TOTAL_RESET);
            addr_count   = int'(COUNT_RESET);
            cap_secs     = int'(CAP_RESET);
            used_secs    = 0;
            deferred     = '0;
            due_grants.delete();
        end else begin
            // Mirror register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TOTAL: budget_total = int'(i_cfg_data);
                    REG_COUNT: addr_count   = int'(i_cfg_data[COUNT_W-1:0]);
                    REG_CAP:   cap_secs     = int'(i_cfg_data);
                    default: ;
                endcase
            end
            // Compare the word leaving the block with the oldest prediction
            if (i_done) begin
                if (due_grants.size() == 0) begin
                    flag_mismatch("result with nothing due, grant_seconds",
                                  i_grant_seconds, '0);
                end else begin
                    want = due_grants.pop_front();
                    if (i_granted !== want.granted)
                        flag_mismatch("granted", 16'(i_granted), 16'(want.granted));
                    if (i_grant_seconds !== want.grant_seconds)
                        flag_mismatch("grant_seconds", i_grant_seconds, want.grant_seconds);
                    if (i_shortened !== want.shortened)
                        flag_mismatch("shortened", 16'(i_shortened), 16'(want.shortened));
                end
            end
            // Predict the word taken at this edge
            if (i_start && !i_busy) begin
                word.opcode          = t_opcode'(i_opcode);
                word.address_index   = i_address_index;
                word.elapsed_seconds = i_elapsed_seconds;
                word.spent_seconds   = i_spent_seconds;
                word.expired         = i_expired;
                word.was_capped      = i_was_capped;
                due_grants.push_back(budget_decide(word));
            end
        end
        o_grants_due = due_grants.size();
    end

endmodule

// ===== tb/tb_retry_timeout_budget_core.sv =====
// Testbench top for the retry timeout budget core: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_retry_timeout_budget_core;
    import rtb_pkg::*;

    localparam int QUIET_LIMIT = 500;

    logic                  i_clk             = 1'b0;
    logic                  i_rst_n           = 1'b0;
    logic                  i_start           = 1'b0;
    logic [1:0]            i_opcode          = '0;
    logic [INDEX_W-1:0]    i_address_index   = '0;
    logic [SECS_W-1:0]     i_elapsed_seconds = '0;
    logic [SECS_W-1:0]     i_spent_seconds   = '0;
    logic                  i_expired         = 1'b0;
    logic                  i_was_capped      = 1'b0;
    logic                  i_cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index       = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data        = '0;

    logic              o_busy;
    logic              o_done;
    logic              o_granted;
    logic [SECS_W-1:0] o_grant_seconds;
    logic              o_shortened;

    int mismatches;
    int grants_due;
    int quiet_cycles = 0;
    int words_sent   = 0;
    bit gaps_on      = 1'b1;

    // Register values currently loaded, used to shape the attempt sequences
    int cfg_total = 0;
    int cfg_count = 0;
    int cfg_cap   = 10;

    always #5 i_clk = ~i_clk;

    retry_timeout_budget_core uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_opcode          (i_opcode),
        .i_address_index   (i_address_index),
        .i_elapsed_seconds (i_elapsed_seconds),
        .i_spent_seconds   (i_spent_seconds),
        .i_expired         (i_expired),
        .i_was_capped      (i_was_capped),
        .o_done            (o_done),
        .o_granted         (o_granted),
        .o_grant_seconds   (o_grant_seconds),
        .o_shortened       (o_shortened),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    retry_budget_checker budget_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .i_busy            (o_busy),
        .i_opcode          (i_opcode),
        .i_address_index   (i_address_index),
        .i_elapsed_seconds (i_elapsed_seconds),
        .i_spent_seconds   (i_spent_seconds),
        .i_expired         (i_expired),
        .i_was_capped      (i_was_capped),
        .i_done            (o_done),
        .i_granted         (o_granted),
        .i_grant_seconds   (o_grant_seconds),
        .i_shortened       (o_shortened),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_mismatches      (mismatches),
        .o_grants_due      (grants_due)
    );

    // Abort when neither a word goes in nor a result comes out for too long
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic t_item word_of(input t_opcode op, input int idx, input int elapsed,
                                      input int secs, input bit tout, input bit capped);
        t_item w;
        w.opcode          = op;
        w.address_index   = INDEX_W'(idx);
        w.elapsed_seconds = SECS_W'(elapsed);
        w.spent_seconds   = SECS_W'(secs);
        w.expired         = tout;
        w.was_capped      = capped;
        return w;
    endfunction

    // Zero and all-ones now and then, otherwise a value in range
    function automatic int pick_limit(input int lo, input int hi);
        int pick;
        pick = $urandom_range(0, 5);
        if (pick == 0) begin
            return 0;
        end else if (pick == 1) begin
            return int'(SECS_MAX);
        end
        return $urandom_range(lo, hi);
    endfunction

    // Present one word, with an optional idle burst first, and hold it until taken
    task automatic send_word(input t_item w);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start           <= 1'b1;
        i_opcode          <= w.opcode;
        i_address_index   <= w.address_index;
        i_elapsed_seconds <= w.elapsed_seconds;
        i_spent_seconds   <= w.spent_seconds;
        i_expired         <= w.expired;
        i_was_capped      <= w.was_capped;
        do @(posedge i_clk); while (o_busy);
        words_sent++;
    endtask

    // Stop sending and wait until every predicted grant has come out
    task automatic settle();
        i_start <= 1'b0;
        @(negedge i_clk);
        while (grants_due != 0) @(negedge i_clk);
        // let the two-stage pipe drain
        repeat (4) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic set_reg(input t_cfg_reg r, input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
    endtask

    task automatic configure(input int total, input int count, input int cap, input bit spare);
        settle();
        set_reg(REG_TOTAL, total);
        set_reg(REG_COUNT, count);
        set_reg(REG_CAP, cap);
        // a write to the unused index must change nothing
        if (spare) set_reg(REG_SPARE, $urandom_range(0, 65535));
        i_cfg_we  <= 1'b0;
        cfg_total = total;
        cfg_count = count % 64;
        cfg_cap   = cap;
    endtask

    // Walk the address list as a caller would, then ask about retries
    task automatic run_attempts();
        int clock_now;
        int addrs;
        int i;
        int retries;
        clock_now = (cfg_total == 0) ? $urandom_range(0, 2000) : $urandom_range(0, cfg_total);
        addrs = (cfg_count > 32) ? 32 : cfg_count;
        for (i = 0; i < addrs; i++) begin
            send_word(word_of(OP_FIRST, i, clock_now, $urandom_range(0, 65535), 1'b0, 1'b0));
            clock_now += $urandom_range(0, 40);
            if (clock_now > int'(SECS_MAX)) clock_now = int'(SECS_MAX);
            send_word(word_of(OP_DONE, i, clock_now, $urandom_range(0, 20),
                              $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1))));
            if ($urandom_range(0, 5) == 0) break;
        end
        retries = $urandom_range(0, 3);
        repeat (retries) begin
            send_word(word_of(OP_RETRY, (addrs > 0) ? $urandom_range(0, addrs - 1)
                                                    : $urandom_range(0, 31),
                              clock_now, $urandom_range(0, 65535), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1))));
        end
    endtask

    // Any opcode, any field value but a limited spent time on timed-out done words
    task automatic send_noise();
        t_item w;
        w.opcode          = t_opcode'($urandom_range(0, 3));
        w.address_index   = INDEX_W'($urandom_range(0, 31));
        w.elapsed_seconds = SECS_W'($urandom_range(0, 65535));
        w.expired         = 1'($urandom_range(0, 1));
        w.was_capped      = 1'($urandom_range(0, 1));
        // keep the spent total from saturating before the end of the run
        w.spent_seconds = SECS_W'((w.opcode == OP_DONE && w.expired) ? $urandom_range(0, 255)
                                                                     : $urandom_range(0, 65535));
        send_word(w);
    endtask

    initial begin : stimulus
        int phase;
        int target;
        int count;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: no addresses, so nothing is granted
        send_word(word_of(OP_FIRST, 0, 0, 0, 1'b0, 1'b0));
        send_word(word_of(OP_NONE, 31, 65535, 65535, 1'b1, 1'b1));

        // Small budget, three addresses, cap of ten
        configure(100, 3, 10, 1'b1);
        send_word(word_of(OP_FIRST, 0, 0, 0, 1'b0, 1'b0));
        send_word(word_of(OP_FIRST, 2, 5, 0, 1'b0, 1'b0));
        send_word(word_of(OP_FIRST, 3, 0, 0, 1'b0, 1'b0));
        send_word(word_of(OP_DONE, 0, 0, 10, 1'b1, 1'b1));
        send_word(word_of(OP_DONE, 1, 0, 50, 1'b0, 1'b1));
        send_word(word_of(OP_RETRY, 0, 0, 0, 1'b0, 1'b0));
        send_word(word_of(OP_RETRY, 1, 0, 0, 1'b0, 1'b0));
        send_word(word_of(OP_FIRST, 0, 100, 0, 1'b0, 1'b0));
        send_word(word_of(OP_FIRST, 1, 95, 0, 1'b0, 1'b0));
        send_word(word_of(OP_RETRY, 0, 90, 0, 1'b0, 1'b0));
        send_word(word_of(OP_FIRST, 2, 0, 0, 1'b0, 1'b0));
        send_word(word_of(OP_NONE, 0, 0, 0, 1'b0, 1'b0));

        // Unlimited budget, full list, widest cap
        configure(0, 32, 65535, 1'b0);
        send_word(word_of(OP_FIRST, 30, 65535, 0, 1'b0, 1'b0));
        send_word(word_of(OP_FIRST, 31, 0, 0, 1'b0, 1'b0));
        send_word(word_of(OP_RETRY, 0, 0, 0, 1'b0, 1'b0));

        // Random phases, mostly attempt sequences; the last one runs without gaps
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       count = $urandom_range(3, 8);
                1:       count = 32;
                2:       count = 63;
                3:       count = 1;
                4:       count = 2;
                default: count = $urandom_range(0, 32);
            endcase
            configure(pick_limit(200, 65535), count, pick_limit(1, 2000), phase == 2);
            gaps_on = (phase < 5);
            target = words_sent + 100;
            while (words_sent < target) begin
                if ($urandom_range(0, 3) != 0) begin
                    run_attempts();
                end else begin
                    send_noise();
                end
            end
        end

        // Saturate the spent time, then nothing is left to grant
        configure(65535, 2, 0, 1'b0);
        send_word(word_of(OP_RETRY, 31, 0, 0, 1'b0, 1'b0));
        send_word(word_of(OP_DONE, 31, 0, 65535, 1'b1, 1'b1));
        send_word(word_of(OP_FIRST, 0, 0, 0, 1'b0, 1'b0));
        send_word(word_of(OP_RETRY, 31, 0, 0, 1'b0, 1'b0));

        settle();
        repeat (4) @(negedge i_clk);
        if (mismatches == 0 && grants_due == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
